FILE: hw/rtl/esq_pkg.sv
// Shared constants and types for the event slot queue.
package esq_pkg;

	localparam int DEF_QUEUE_DEPTH   = 16;
	localparam int DEF_PAYLOAD_WIDTH = 32;
	localparam int ID_W              = 16;
	localparam int CFG_W             = 5;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	localparam logic FUNC_POST  = 1'b0;
	localparam logic FUNC_RECV  = 1'b1;
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POST,
		ST_RECV,
		ST_FAIL
	} state_t;

endpackage

FILE: hw/rtl/event_slot_queue.sv
// Event slot queue: slot table with post and id-matched circular receive.
//
//  channel  | handshake            | fields
//  ---------+----------------------+-----------------------------------------
//  command  | start / busy         | func, post_id, post_payload, want_id
//  result   | done (1-cycle pulse) | status, got_id, got_payload, slot_used
//  config   | cfg_wr_en            | cfg_wr_data (slots_in_use)
//
// One item at a time; the slot scan walks one slot per cycle through a single
// compare unit and the table RAM's one port. A post scans up from slot zero
// to the first free slot, or stops at the last slot in use when full.
// A receive scans circularly from the pointer via the registered RAM read.
// Reset clears all valid bits, the scan pointer and sets slots_in_use to 16.
// The receiver cannot stall; done is a single-cycle strobe.
module event_slot_queue #(
	parameter int QUEUE_DEPTH   = esq_pkg::DEF_QUEUE_DEPTH,
	parameter int PAYLOAD_WIDTH = esq_pkg::DEF_PAYLOAD_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             func,
	input  logic [esq_pkg::ID_W-1:0]         post_id,
	input  logic [PAYLOAD_WIDTH-1:0]         post_payload,
	input  logic [esq_pkg::ID_W-1:0]         want_id,
	input  logic                             cfg_wr_en,
	input  logic [esq_pkg::CFG_W-1:0]        cfg_wr_data,
	output logic                             done,
	output logic                             status,
	output logic [esq_pkg::ID_W-1:0]         got_id,
	output logic [PAYLOAD_WIDTH-1:0]         got_payload,
	output logic [$clog2(QUEUE_DEPTH)-1:0]   slot_used
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_W = esq_pkg::ID_W + PAYLOAD_WIDTH;

	typedef struct packed {
		logic issue;
		logic post_hit;
		logic post_full;
		logic recv_hit;
		logic recv_miss;
		logic fail;
	} ctl_t;

	esq_pkg::state_t state_q, state_d;
	ctl_t            ctl;

	logic [esq_pkg::CFG_W-1:0] cfg_q;
	logic [QUEUE_DEPTH-1:0]    valid_q;
	logic [IDX_W-1:0]          ptr_q;
	logic [IDX_W-1:0]          k_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          n_q;
	logic [esq_pkg::ID_W-1:0]  id_q;
	logic [PAYLOAD_WIDTH-1:0]  pay_q;
	logic [esq_pkg::ID_W-1:0]  want_q;

	logic                      vld_s1;
	logic                      slotv_s1;
	logic                      last_s1;
	logic [IDX_W-1:0]          k_s1;

	logic                      accept;
	logic [CNT_W-1:0]          n_d;
	logic [IDX_W-1:0]          start_k;
	logic [IDX_W-1:0]          last_k;
	logic [ENT_W-1:0]          rdata;
	logic [esq_pkg::ID_W-1:0]  rd_id;
	logic [PAYLOAD_WIDTH-1:0]  rd_pay;
	logic                      id_match;

	assign busy    = (state_q != esq_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign n_d     = (int'(cfg_q) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(cfg_q);
	// an out-of-range pointer restarts the scan at slot zero
	assign start_k = (CNT_W'(ptr_q) < n_d) ? ptr_q : '0;
	assign last_k  = IDX_W'(n_q - CNT_W'(1));
	assign rd_id   = rdata[ENT_W-1 -: esq_pkg::ID_W];
	assign rd_pay  = rdata[PAYLOAD_WIDTH-1:0];
	assign id_match = (want_q == '0) || (rd_id == want_q);

	esq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ctl.post_hit),
		.addr (k_q),
		.wdata({id_q, pay_q}),
		.rdata(rdata)
	);

	// control decode
	always_comb begin
		ctl = '0;
		case (state_q)
			esq_pkg::ST_POST: begin
				if (!valid_q[k_q]) begin
					ctl.post_hit = 1'b1;
				end else if (k_q == last_k) begin
					ctl.post_full = 1'b1;
				end
			end
			esq_pkg::ST_RECV: begin
				ctl.issue = (cnt_q < n_q);
				if (vld_s1 && slotv_s1 && id_match) begin
					ctl.recv_hit = 1'b1;
				end else if (vld_s1 && last_s1) begin
					ctl.recv_miss = 1'b1;
				end
			end
			esq_pkg::ST_FAIL: begin
				ctl.fail = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			esq_pkg::ST_IDLE: begin
				if (accept) begin
					if (n_d == '0) begin
						state_d = esq_pkg::ST_FAIL;
					end else if (func == esq_pkg::FUNC_POST) begin
						state_d = esq_pkg::ST_POST;
					end else begin
						state_d = esq_pkg::ST_RECV;
					end
				end
			end
			esq_pkg::ST_POST: begin
				if (ctl.post_hit || ctl.post_full) begin
					state_d = esq_pkg::ST_IDLE;
				end
			end
			esq_pkg::ST_RECV: begin
				if (ctl.recv_hit || ctl.recv_miss) begin
					state_d = esq_pkg::ST_IDLE;
				end
			end
			esq_pkg::ST_FAIL: begin
				state_d = esq_pkg::ST_IDLE;
			end
			default: begin
				state_d = esq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= esq_pkg::ST_IDLE;
			cfg_q    <= esq_pkg::CFG_RESET;
			valid_q  <= '0;
			ptr_q    <= '0;
			k_q      <= '0;
			cnt_q    <= '0;
			n_q      <= '0;
			vld_s1   <= 1'b0;
			done     <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= ctl.issue;
			done    <= ctl.post_hit || ctl.post_full || ctl.recv_hit
				|| ctl.recv_miss || ctl.fail;
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (accept) begin
				n_q   <= n_d;
				cnt_q <= '0;
				if (func == esq_pkg::FUNC_RECV) begin
					k_q <= start_k;
					if (n_d != '0) begin
						ptr_q <= start_k;
					end
				end else begin
					k_q <= '0;
				end
			end
			if (state_q == esq_pkg::ST_POST && !ctl.post_hit && !ctl.post_full) begin
				k_q <= k_q + IDX_W'(1);
			end
			if (ctl.issue) begin
				k_q   <= (k_q == last_k) ? '0 : k_q + IDX_W'(1);
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ctl.post_hit) begin
				valid_q[k_q] <= 1'b1;
			end
			if (ctl.recv_hit) begin
				valid_q[k_s1] <= 1'b0;
				ptr_q         <= k_s1;
			end
		end
	end

	// item fields, compare stage and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= post_id;
			pay_q  <= post_payload;
			want_q <= want_id;
		end
		k_s1     <= k_q;
		slotv_s1 <= valid_q[k_q];
		last_s1  <= (cnt_q == n_q - CNT_W'(1));
		status      <= esq_pkg::STATUS_ERR;
		got_id      <= '0;
		got_payload <= '0;
		slot_used   <= '0;
		if (ctl.post_hit) begin
			status    <= esq_pkg::STATUS_OK;
			slot_used <= k_q;
		end
		if (ctl.recv_hit) begin
			status      <= esq_pkg::STATUS_OK;
			got_id      <= rd_id;
			got_payload <= rd_pay;
			slot_used   <= k_s1;
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in progress");

	a_post_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.post_hit |=> valid_q[$past(k_q)])
		else $error("posted slot not marked valid");

	a_recv_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.recv_hit |=> !valid_q[$past(k_s1)] && ptr_q == $past(k_s1))
		else $error("taken slot still valid or pointer not moved");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == esq_pkg::ST_POST || state_q == esq_pkg::ST_RECV)
			|-> CNT_W'(k_q) < n_q)
		else $error("scan index beyond slots in use");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == esq_pkg::STATUS_ERR)
			|-> got_id == '0 && got_payload == '0 && slot_used == '0)
		else $error("error result carries data");

endmodule

FILE: hw/rtl/esq_ram.sv
// Generic single-port RAM with registered read.
module esq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: bench/tb_event_slot_queue.sv
// Self-checking bench for event_slot_queue: posts and id-matched receives against a slot table model.
`timescale 1ns / 1ps

module tb_event_slot_queue;
	import esq_pkg::*;

	localparam int DEPTH          = DEF_QUEUE_DEPTH;
	localparam int PW             = DEF_PAYLOAD_WIDTH;
	localparam int SLOT_W         = $clog2(DEPTH);
	localparam int N_PHASES       = 11;
	localparam int ITEMS_PER_PHASE = 41;
	localparam int DRAIN_CYCLES   = 30;
	localparam int WATCHDOG_LIMIT = 400;

	typedef struct packed {
		logic              status;
		logic [ID_W-1:0]   id;
		logic [PW-1:0]     payload;
		logic [SLOT_W-1:0] slot;
	} evt_result_t;

	typedef enum logic {ROW_ITEM, ROW_SLOTS} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic              f;
		logic [ID_W-1:0]   pid;
		logic [PW-1:0]     pay;
		logic [ID_W-1:0]   wid;
		logic [CFG_W-1:0]  slots;
		bit                typed;
		evt_result_t       res;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              func;
	logic [ID_W-1:0]   post_id;
	logic [PW-1:0]     post_payload;
	logic [ID_W-1:0]   want_id;
	logic              cfg_wr_en;
	logic [CFG_W-1:0]  cfg_wr_data;
	logic              done;
	logic              status;
	logic [ID_W-1:0]   got_id;
	logic [PW-1:0]     got_payload;
	logic [SLOT_W-1:0] slot_used;

	// slot table as the bench sees it
	logic              tbl_valid [DEPTH];
	logic [ID_W-1:0]   tbl_id    [DEPTH];
	logic [PW-1:0]     tbl_pay   [DEPTH];
	int                scan_ptr;
	logic [CFG_W-1:0]  slots_cfg;

	evt_result_t       pending_results [$];
	dir_row_t          dir_tab [$];
	int                phase_slots [N_PHASES];

	int errors;
	int n_checked;
	int n_post;
	int n_full;
	int n_recv;
	int n_nomatch;
	int stall_cnt;

	event_slot_queue #(
		.QUEUE_DEPTH  (DEPTH),
		.PAYLOAD_WIDTH(PW)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.post_id     (post_id),
		.post_payload(post_payload),
		.want_id     (want_id),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.done        (done),
		.status      (status),
		.got_id      (got_id),
		.got_payload (got_payload),
		.slot_used   (slot_used)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic dir_row_t mk_item(logic f, logic [ID_W-1:0] pid, logic [PW-1:0] pay,
			logic [ID_W-1:0] wid);
		dir_row_t r;
		r.kind  = ROW_ITEM;
		r.f     = f;
		r.pid   = pid;
		r.pay   = pay;
		r.wid   = wid;
		r.slots = '0;
		r.typed = 1'b0;
		r.res   = '0;
		return r;
	endfunction

	function automatic dir_row_t mk_known(logic f, logic [ID_W-1:0] pid, logic [PW-1:0] pay,
			logic [ID_W-1:0] wid, logic st, logic [ID_W-1:0] gid, logic [PW-1:0] gpay,
			logic [SLOT_W-1:0] slot);
		dir_row_t r;
		r = mk_item(f, pid, pay, wid);
		r.typed = 1'b1;
		r.res   = '{status: st, id: gid, payload: gpay, slot: slot};
		return r;
	endfunction

	function automatic dir_row_t mk_slots(logic [CFG_W-1:0] v);
		dir_row_t r;
		r = mk_item(FUNC_POST, '0, '0, '0);
		r.kind  = ROW_SLOTS;
		r.slots = v;
		return r;
	endfunction

	// one post or receive on the table; updates the bench's table and pointer
	function automatic evt_result_t slot_table_step(logic f, logic [ID_W-1:0] pid,
			logic [PW-1:0] pay, logic [ID_W-1:0] wid);
		int n;
		int k;
		evt_result_t r;
		n = (slots_cfg > DEPTH) ? DEPTH : int'(slots_cfg);
		r = '{status: STATUS_ERR, id: '0, payload: '0, slot: '0};
		if (f == FUNC_POST) begin
			for (int i = 0; i < n; i++) begin
				if (!tbl_valid[i]) begin
					tbl_valid[i] = 1'b1;
					tbl_id[i]    = pid;
					tbl_pay[i]   = pay;
					r.status     = STATUS_OK;
					r.slot       = SLOT_W'(i);
					break;
				end
			end
		end else if (n > 0) begin
			// a pointer left beyond a shrunk table restarts the scan at slot 0
			k = (scan_ptr < n) ? scan_ptr : 0;
			scan_ptr = k;
			for (int i = 0; i < n; i++) begin
				if (tbl_valid[k] && (wid == '0 || tbl_id[k] == wid)) begin
					r.status     = STATUS_OK;
					r.id         = tbl_id[k];
					r.payload    = tbl_pay[k];
					r.slot       = SLOT_W'(k);
					tbl_valid[k] = 1'b0;
					tbl_id[k]    = '0;
					tbl_pay[k]   = '0;
					scan_ptr     = k;
					break;
				end
				k = (k + 1 >= n) ? 0 : k + 1;
			end
		end
		return r;
	endfunction

	task automatic send_evt(input logic f, input logic [ID_W-1:0] pid, input logic [PW-1:0] pay,
			input logic [ID_W-1:0] wid, input bit typed, input evt_result_t known);
		evt_result_t r;
		@(negedge clk);
		start        <= 1'b1;
		func         <= f;
		post_id      <= pid;
		post_payload <= pay;
		want_id      <= wid;
		do @(posedge clk); while (busy !== 1'b0);
		r = slot_table_step(f, pid, pay, wid);
		if (typed)
			r = known;
		pending_results.push_back(r);
		if (f == FUNC_POST) begin
			n_post++;
			if (r.status == STATUS_ERR)
				n_full++;
		end else begin
			n_recv++;
			if (r.status == STATUS_ERR)
				n_nomatch++;
		end
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// only written with the block idle and every result in
	task automatic write_slots(input logic [CFG_W-1:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy !== 1'b0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		slots_cfg = v;
	endtask

	always @(posedge clk) begin
		evt_result_t e;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status=%0d got_id=%0h slot_used=%0d",
					status, got_id, slot_used);
				errors++;
			end else begin
				e = pending_results.pop_front();
				n_checked++;
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					errors++;
				end
				if (got_id !== e.id) begin
					$error("got_id: expected %0h, got %0h", e.id, got_id);
					errors++;
				end
				if (got_payload !== e.payload) begin
					$error("got_payload: expected %0h, got %0h", e.payload, got_payload);
					errors++;
				end
				if (slot_used !== e.slot) begin
					$error("slot_used: expected %0d, got %0d", e.slot, slot_used);
					errors++;
				end
			end
		end
	end

	// counts cycles in which neither an item nor a result is taken
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt == WATCHDOG_LIMIT) begin
			$display("tb_event_slot_queue: FAIL");
			$finish;
		end
	end

	initial begin
		logic              f;
		logic [ID_W-1:0]   pid;
		logic [ID_W-1:0]   wid;
		logic [PW-1:0]     pay;
		int                n_act;
		int                fill;
		int                pick;
		int                post_pct;
		bit                idle_on;

		arst_n       = 1'b0;
		start        = 1'b0;
		func         = FUNC_POST;
		post_id      = '0;
		post_payload = '0;
		want_id      = '0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		errors       = 0;
		n_checked    = 0;
		n_post       = 0;
		n_full       = 0;
		n_recv       = 0;
		n_nomatch    = 0;
		stall_cnt    = 0;
		scan_ptr     = 0;
		slots_cfg    = CFG_RESET;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_id[i]    = '0;
			tbl_pay[i]   = '0;
		end

		phase_slots = '{16, 1, 2, 0, 31, 17, 3, 8, 15, 5, 16};

		dir_tab = '{
			// empty table after reset: nothing to receive
			mk_known(FUNC_RECV, 16'h0000, 32'h0, 16'h0000, STATUS_ERR, 16'h0, 32'h0, 4'd0),
			mk_known(FUNC_RECV, 16'h0000, 32'h0, 16'hFFFF, STATUS_ERR, 16'h0, 32'h0, 4'd0),
			mk_known(FUNC_POST, 16'hFFFF, 32'hFFFF_FFFF, 16'h0, STATUS_OK, 16'h0, 32'h0, 4'd0),
			// id zero is stored as is
			mk_known(FUNC_POST, 16'h0000, 32'h0, 16'h0, STATUS_OK, 16'h0, 32'h0, 4'd1),
			mk_known(FUNC_POST, 16'h1234, 32'hA5A5_A5A5, 16'h0, STATUS_OK, 16'h0, 32'h0, 4'd2),
			mk_known(FUNC_RECV, 16'h0, 32'h0, 16'h1234, STATUS_OK, 16'h1234, 32'hA5A5_A5A5, 4'd2),
			// any-id receive wraps round from slot 2 to slot 0
			mk_known(FUNC_RECV, 16'h0, 32'h0, 16'h0000, STATUS_OK, 16'hFFFF, 32'hFFFF_FFFF, 4'd0),
			mk_known(FUNC_RECV, 16'h0, 32'h0, 16'h0000, STATUS_OK, 16'h0000, 32'h0, 4'd1),
			mk_known(FUNC_RECV, 16'h0, 32'h0, 16'h0001, STATUS_ERR, 16'h0, 32'h0, 4'd0),
			mk_slots(5'd2),
			mk_known(FUNC_POST, 16'h0007, 32'h1, 16'h0, STATUS_OK, 16'h0, 32'h0, 4'd0),
			mk_known(FUNC_POST, 16'h0008, 32'h2, 16'h0, STATUS_OK, 16'h0, 32'h0, 4'd1),
			mk_known(FUNC_POST, 16'h0009, 32'h3, 16'h0, STATUS_ERR, 16'h0, 32'h0, 4'd0),
			mk_item(FUNC_RECV, 16'h0, 32'h0, 16'h0008),
			// pointer now sits past the single slot in use
			mk_slots(5'd1),
			mk_known(FUNC_RECV, 16'h0, 32'h0, 16'h0005, STATUS_ERR, 16'h0, 32'h0, 4'd0),
			mk_known(FUNC_RECV, 16'h0, 32'h0, 16'h0007, STATUS_OK, 16'h0007, 32'h1, 4'd0),
			mk_slots(5'd0),
			mk_known(FUNC_POST, 16'h0003, 32'h3, 16'h0, STATUS_ERR, 16'h0, 32'h0, 4'd0),
			mk_known(FUNC_RECV, 16'h0, 32'h0, 16'h0000, STATUS_ERR, 16'h0, 32'h0, 4'd0),
			// above the built depth: behaves as the full table
			mk_slots(5'd31),
			mk_item(FUNC_POST, 16'h8000, 32'h8000_0000, 16'h0),
			mk_known(FUNC_RECV, 16'h0, 32'h0, 16'h8000, STATUS_OK, 16'h8000, 32'h8000_0000, 4'd0),
			mk_item(FUNC_POST, 16'h00FF, 32'h5A5A_5A5A, 16'h0)
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_SLOTS)
				write_slots(dir_tab[i].slots);
			else
				send_evt(dir_tab[i].f, dir_tab[i].pid, dir_tab[i].pay, dir_tab[i].wid,
					dir_tab[i].typed, dir_tab[i].res);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			write_slots(5'(phase_slots[p]));
			idle_on  = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
			post_pct = (p % 2 == 1) ? 70 : 40;
			repeat (ITEMS_PER_PHASE) begin
				if (idle_on && $urandom_range(0, 3) == 0)
					pause_sender($urandom_range(1, 4));
				n_act = (slots_cfg > DEPTH) ? DEPTH : int'(slots_cfg);
				fill = 0;
				for (int i = 0; i < n_act; i++)
					if (tbl_valid[i])
						fill++;
				if (fill == n_act)
					f = ($urandom_range(0, 99) < 30) ? FUNC_POST : FUNC_RECV;
				else if (fill == 0)
					f = ($urandom_range(0, 99) < 80) ? FUNC_POST : FUNC_RECV;
				else
					f = ($urandom_range(0, 99) < post_pct) ? FUNC_POST : FUNC_RECV;
				// a small id pool makes duplicate ids common
				pid = ($urandom_range(0, 9) < 3) ? ID_W'($urandom_range(1, 4))
					: ID_W'($urandom_range(0, 65535));
				pay = PW'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 60 && fill > 0) begin
					pick = $urandom_range(0, fill - 1);
					wid = '0;
					for (int i = 0; i < n_act; i++) begin
						if (tbl_valid[i]) begin
							if (pick == 0)
								wid = tbl_id[i];
							pick--;
						end
					end
				end else if (pick < 75) begin
					wid = '0;
				end else begin
					wid = ID_W'($urandom_range(0, 65535));
				end
				send_evt(f, pid, pay, wid, 1'b0, '0);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d posts (%0d refused, table full) and %0d receives (%0d unmatched),",
			n_post, n_full, n_recv, n_nomatch);
		$display("with slot counts from 0 to 31 and %0d results compared.", n_checked);
		if (errors == 0)
			$display("tb_event_slot_queue: PASS");
		else
			$display("tb_event_slot_queue: FAIL");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/esq_pkg.sv
hw/rtl/esq_ram.sv
hw/rtl/event_slot_queue.sv
bench/tb_event_slot_queue.sv
